// ===== hw/rtl/nmt_frc_pkg.sv =====
// ----------------------------------------------------------------------------
// nmt_frc_pkg
// types, constants and helpers shared by the frame receive check stages
// ----------------------------------------------------------------------------
`default_nettype none

package nmt_frc_pkg;

  localparam int unsigned BodyBits   = 140;
  localparam int unsigned InfoBits   = 70;
  localparam int unsigned InfoSkip   = 6;
  localparam int unsigned DataBits   = 64;
  localparam int unsigned ShortLimit = 48;
  localparam int unsigned TailStart  = 64;
  localparam int unsigned OnesStart  = 67;

  localparam logic [3:0] PrefixCallAck = 4'd1;
  localparam logic [3:0] PrefixFifteen = 4'd15;

  localparam logic [11:0] TailMeterLo = 12'h3f3;
  localparam logic [11:0] TailMeterHi = 12'h3f6;
  localparam logic [11:0] TailIdle    = 12'h3f0;
  localparam logic [11:0] TailRelease = 12'h3f1;
  localparam logic [11:0] TailClear   = 12'h3f2;

  localparam logic [5:0] TypeCallAck   = 6'd15;
  localparam logic [5:0] TypeSpareDown = 6'd43;
  localparam logic [5:0] TypeSpareUp   = 6'd44;

  // stage 1 -> stage 2
  typedef struct packed {
    logic [DataBits-1:0] x;        // x(0) in the top bit
    logic [InfoBits-1:0] par;      // p(j) in bit j
    logic                info_ok;
    logic                up;
    logic                ack;
  } unpack_t;

  // stage 2 -> stage 3
  typedef struct packed {
    logic [DataBits-1:0] digits;
    logic                ok;
    logic                short_f;
    logic                up;
    logic                ack;
  } chk_t;

  // stage 3 result
  typedef struct packed {
    logic [DataBits-1:0] digits;
    logic                ok;
    logic                short_f;
    logic [5:0]          ftype;
    logic                known;
  } res_t;

  // digit k of a 16-digit word, digit 0 in the top nibble
  function automatic logic [3:0] get_digit(input logic [DataBits-1:0] d,
                                           input logic [3:0] k);
    logic [DataBits-1:0] sh;
    sh = d >> ({2'b00, 4'd15 - k} * 6'd4);
    return sh[3:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/nmt_frc_unpack.sv =====
// ----------------------------------------------------------------------------
// nmt_frc_unpack
// splits the frame body into information and parity bits, checks leading zeros
// ----------------------------------------------------------------------------
`default_nettype none

module nmt_frc_unpack
  import nmt_frc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  output logic                     ready_o,
  input  wire logic [BodyBits-1:0] body_i,   // body bit 0 in the top bit
  input  wire logic                up_i,
  input  wire logic                ack_i,
  output logic                     valid_o,
  input  wire logic                ready_i,
  output unpack_t                  data_o
);

  logic    valid_q;
  unpack_t data_d, data_q;

  always_comb begin
    data_d = '0;
    for (int j = 0; j < InfoBits; j++) begin
      data_d.par[j] = body_i[BodyBits-1-2*j];
    end
    for (int j = 0; j < DataBits; j++) begin
      data_d.x[DataBits-1-j] = body_i[BodyBits-2-2*(j+InfoSkip)];
    end
    data_d.info_ok = 1'b1;
    for (int j = 0; j < InfoSkip; j++) begin
      if (body_i[BodyBits-2-2*j]) data_d.info_ok = 1'b0;
    end
    data_d.up  = up_i;
    data_d.ack = ack_i;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/nmt_frc_parity.sv =====
// ----------------------------------------------------------------------------
// nmt_frc_parity
// parity check against the inverted code and shortened frame handling
// ----------------------------------------------------------------------------
`default_nettype none

module nmt_frc_parity
  import nmt_frc_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    valid_i,
  output logic         ready_o,
  input  wire unpack_t data_i,
  output logic         valid_o,
  input  wire logic    ready_i,
  output chk_t         data_o
);

  logic                valid_q;
  chk_t                data_d, data_q;
  logic [InfoBits-1:0] mism;
  logic [3:0]          prefix;
  logic                short_f;
  logic                head_err, mid_err, tail_err;

  always_comb begin
    for (int j = 0; j < InfoBits; j++) begin
      if (j < 3) begin
        mism[j] = data_i.par[j] != !data_i.x[DataBits-1-j];
      end else if (j < TailStart) begin
        mism[j] = data_i.par[j] != !(data_i.x[DataBits-1-j] ^ data_i.x[DataBits+2-j]);
      end else if (j < OnesStart) begin
        mism[j] = data_i.par[j] != !data_i.x[DataBits+2-j];
      end else begin
        mism[j] = !data_i.par[j];
      end
    end
  end

  assign head_err = |mism[ShortLimit-1:0];
  assign mid_err  = |mism[TailStart-1:ShortLimit];
  assign tail_err = |mism[InfoBits-1:TailStart];
  assign prefix   = get_digit(data_i.x, 4'd3);
  assign short_f  = data_i.ack && (prefix == PrefixCallAck || prefix == PrefixFifteen);

  always_comb begin
    data_d         = '0;
    data_d.digits  = short_f ? {data_i.x[DataBits-1:12], 12'h000} : data_i.x;
    data_d.ok      = data_i.info_ok && !head_err && (short_f || (!mid_err && !tail_err));
    data_d.short_f = short_f;
    data_d.up      = data_i.up;
    data_d.ack     = data_i.ack;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/nmt_frc_classify.sv =====
// ----------------------------------------------------------------------------
// nmt_frc_classify
// frame type lookup from prefix and direction, result register
// ----------------------------------------------------------------------------
`default_nettype none

module nmt_frc_classify
  import nmt_frc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic valid_i,
  output logic      ready_o,
  input  wire chk_t data_i,
  output logic      valid_o,
  input  wire logic ready_i,
  output res_t      data_o
);

  logic       valid_q;
  res_t       data_d, data_q;
  logic [3:0] p, d6, d10, d11, d13;
  logic [11:0] tail;
  logic [5:0] idx;
  logic       known;
  logic       tail_meter;

  assign p    = get_digit(data_i.digits, 4'd3);
  assign d6   = get_digit(data_i.digits, 4'd6);
  assign d10  = get_digit(data_i.digits, 4'd10);
  assign d11  = get_digit(data_i.digits, 4'd11);
  assign d13  = get_digit(data_i.digits, 4'd13);
  assign tail = data_i.digits[11:0];
  assign tail_meter = (tail >= TailMeterLo && tail <= TailMeterHi) || tail == 12'h000;

  always_comb begin
    idx   = '0;
    known = 1'b1;
    if (data_i.up) begin
      case (p)
        4'd0:  idx = 6'd25;
        4'd1:  idx = 6'd16;
        4'd2:  idx = 6'd39;
        4'd4:  idx = 6'd40;
        4'd6:  idx = 6'd17;
        4'd7: begin
          if (d11 == 4'd0) idx = 6'd23;
          else if (d11 == 4'd15) idx = 6'd24;
          else known = 1'b0;
        end
        4'd8:  idx = (d11 == 4'd2) ? 6'd22 : 6'd21;
        4'd9: begin
          if (tail == 12'd2 || tail == 12'd6) idx = 6'd36;
          else if (tail == 12'd14) idx = 6'd37;
          else if (tail == 12'd7 || tail == 12'd8) idx = 6'd38;
          else idx = 6'd35;
        end
        4'd11: idx = 6'd20;
        4'd12: idx = 6'd26;
        4'd13: idx = 6'd41;
        4'd14: idx = 6'd18;
        4'd15: idx = 6'd19;
        default: idx = TypeSpareUp;
      endcase
      if (p == PrefixCallAck && data_i.ack) begin
        idx   = TypeCallAck;
        known = 1'b1;
      end
    end else begin
      case (p)
        4'd0:  idx = 6'd13;
        4'd3:  idx = (d6 == 4'd15) ? 6'd32 : 6'd10;
        4'd4:  idx = 6'd1;
        4'd5: begin
          if (d6 == 4'd15) idx = 6'd33;
          else if (tail_meter) idx = 6'd8;
          else idx = 6'd7;
        end
        4'd6:  idx = (d13 == 4'd0) ? 6'd12 : 6'd11;
        4'd8:  idx = 6'd14;
        4'd9:  idx = 6'd9;
        4'd10: idx = 6'd42;
        4'd12: begin
          if (d6 == 4'd0 || d6 == 4'd14 || d6 == 4'd15) idx = 6'd0;
          else if (tail_meter) idx = 6'd2;
          else if (tail == TailIdle) idx = 6'd6;
          else if (tail == TailRelease) idx = 6'd4;
          else if (tail == TailClear) idx = 6'd5;
          else idx = 6'd3;
        end
        4'd14: idx = (d13 != 4'd15) ? TypeSpareDown : 6'd34;
        4'd15: begin
          if (d13 != 4'd15) begin
            idx = TypeSpareDown;
          end else begin
            case (d10)
              4'd3:          idx = 6'd27;
              4'd6, 4'd13:   idx = 6'd29;
              4'd7, 4'd14:   idx = 6'd30;
              4'd15:         idx = 6'd31;
              default:       idx = 6'd28;
            endcase
          end
        end
        default: idx = TypeSpareDown;
      endcase
    end
  end

  // a bad frame reports nothing but frame_ok low
  always_comb begin
    data_d         = '0;
    data_d.ok      = data_i.ok;
    if (data_i.ok) begin
      data_d.digits  = data_i.digits;
      data_d.short_f = data_i.short_f;
      data_d.ftype   = known ? idx : 6'd0;
      data_d.known   = known;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/nmt_frame_receive_check.sv =====
// ----------------------------------------------------------------------------
// nmt_frame_receive_check
// parity check and frame type classification of received frame bodies
// ----------------------------------------------------------------------------
// channel  dir  tdata (low bits first)                   tuser (low bits first)
// s_axis   in   coded_first, coded_second, coded_third   toward_switch, call_ack
// m_axis   out  recovered_digits, frame_type             frame_ok, shortened, type_known
//
// three register stages: unpack, parity check, classify + result register
// a frame can enter every cycle while the output is not stalled; m_axis_tvalid
// rises once the frame has passed the unpack, parity and classify registers
// each stage advances when empty or when the next one advances, so bubbles
// fill up while the output is stalled and nothing is dropped or repeated
// reset clears only the stage valid bits
// ----------------------------------------------------------------------------
`default_nettype none

module nmt_frame_receive_check
  import nmt_frc_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [143:0] s_axis_tdata,  // coded_first, coded_second, coded_third, 4'b0
  input  wire logic [1:0]   s_axis_tuser,  // toward_switch, call_ack
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [71:0]       m_axis_tdata,  // recovered_digits, frame_type, 2'b0
  output logic [2:0]        m_axis_tuser   // frame_ok, shortened, type_known
);

  logic            v1, r1, v2, r2;
  unpack_t         st1;
  chk_t            st2;
  res_t            res;
  logic [BodyBits-1:0] body;

  assign body = {s_axis_tdata[63:0], s_axis_tdata[127:64], s_axis_tdata[139:128]};

  nmt_frc_unpack u_unpack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .body_i  (body),
    .up_i    (s_axis_tuser[0]),
    .ack_i   (s_axis_tuser[1]),
    .valid_o (v1),
    .ready_i (r1),
    .data_o  (st1)
  );

  nmt_frc_parity u_parity (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1),
    .ready_o (r1),
    .data_i  (st1),
    .valid_o (v2),
    .ready_i (r2),
    .data_o  (st2)
  );

  nmt_frc_classify u_classify (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2),
    .ready_o (r2),
    .data_i  (st2),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (res)
  );

  assign m_axis_tdata = {2'b00, res.ftype, res.digits};
  assign m_axis_tuser = {res.known, res.short_f, res.ok};

`ifndef SYNTH
  a_bad_frame_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !res.ok |-> res.digits == '0 && !res.short_f && !res.known)
    else $error("bad frame result not cleared");

  a_short_tail_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.short_f |-> res.digits[11:0] == 12'h000)
    else $error("shortened frame keeps tail digits");

  a_unknown_type_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !res.known |-> res.ftype == 6'd0)
    else $error("unknown frame carries a type");

  a_stall_ripples: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1 && v2 && m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("full pipeline accepts during stall");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// stream bench for the frame receive parity check and classifier
// ----------------------------------------------------------------------------
// frames go in from a queue through a clocked driver, results are checked
// by a clocked monitor against a predictor of the parity, shortening and
// frame type rules; most frames are built well-formed from random digits,
// some get a flipped bit and the rest are noise
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
  import nmt_frc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 300;

  typedef struct {
    logic [BodyBits-1:0] body;  // body bit 0 in the top bit
    logic                up;
    logic                ack;
  } frame_item_t;

  typedef struct packed {
    logic [DataBits-1:0] digits;
    logic                ok;
    logic                shortf;
    logic [5:0]          ftype;
    logic                known;
  } frame_verdict_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata = '0;   // coded_first, coded_second, coded_third
  logic [1:0]   s_axis_tuser = '0;   // toward_switch, call_ack
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [71:0]  m_axis_tdata;        // recovered_digits, frame_type
  logic [2:0]   m_axis_tuser;        // frame_ok, shortened, type_known

  frame_item_t    pending_frames[$];
  frame_verdict_t expected_verdicts[$];
  int             errors = 0;
  int             send_idle_pct = 0;
  int             recv_idle_pct = 0;
  int             hold_req = 0;
  int             hold_seen;
  int unsigned    hold_left;
  int unsigned    cycle_cnt = 0;

  nmt_frame_receive_check u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [3:0] nib(input logic [DataBits-1:0] d, input int k);
    return d[DataBits-1-4*k -: 4];
  endfunction

  function automatic logic [DataBits-1:0] with_dig(input logic [DataBits-1:0] d,
                                                   input int k, input logic [3:0] v);
    d[DataBits-1-4*k -: 4] = v;
    return d;
  endfunction

  function automatic logic [DataBits-1:0] with_tail(input logic [DataBits-1:0] d,
                                                    input logic [11:0] t);
    d[11:0] = t;
    return d;
  endfunction

  function automatic logic [DataBits-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // frame table index, -1 when no index can be given
  function automatic int frame_class(input logic [DataBits-1:0] d, input logic up);
    logic [11:0] tail;
    logic [3:0]  d6;
    logic [3:0]  d10;
    logic [3:0]  d11;
    logic [3:0]  d13;
    logic        meter_or_zero;
    tail = d[11:0];
    d6 = nib(d, 6);
    d10 = nib(d, 10);
    d11 = nib(d, 11);
    d13 = nib(d, 13);
    meter_or_zero = (tail >= TailMeterLo && tail <= TailMeterHi) || tail == 12'h000;
    if (up) begin
      case (nib(d, 3))
        4'd0: return 25;
        4'd1: return 16;
        4'd2: return 39;
        4'd4: return 40;
        4'd6: return 17;
        4'd7: begin
          if (d11 == 4'd0) return 23;
          if (d11 == 4'd15) return 24;
          return -1;
        end
        4'd8: return (d11 == 4'd2) ? 22 : 21;
        4'd9: begin
          if (tail == 12'd2 || tail == 12'd6) return 36;
          if (tail == 12'd14) return 37;
          if (tail == 12'd7 || tail == 12'd8) return 38;
          return 35;
        end
        4'd11: return 20;
        4'd12: return 26;
        4'd13: return 41;
        4'd14: return 18;
        4'd15: return 19;
        default: return int'(TypeSpareUp);
      endcase
    end
    case (nib(d, 3))
      4'd0: return 13;
      4'd3: return (d6 == 4'd15) ? 32 : 10;
      4'd4: return 1;
      4'd5: begin
        if (d6 == 4'd15) return 33;
        return meter_or_zero ? 8 : 7;
      end
      4'd6: return (d13 == 4'd0) ? 12 : 11;
      4'd8: return 14;
      4'd9: return 9;
      4'd10: return 42;
      4'd12: begin
        if (d6 == 4'd0 || d6 == 4'd14 || d6 == 4'd15) return 0;
        if (meter_or_zero) return 2;
        if (tail == TailIdle) return 6;
        if (tail == TailRelease) return 4;
        if (tail == TailClear) return 5;
        return 3;
      end
      4'd14: return (d13 != 4'd15) ? int'(TypeSpareDown) : 34;
      4'd15: begin
        if (d13 != 4'd15) return int'(TypeSpareDown);
        case (d10)
          4'd3: return 27;
          4'd6, 4'd13: return 29;
          4'd7, 4'd14: return 30;
          4'd15: return 31;
          default: return 28;
        endcase
      end
      default: return int'(TypeSpareDown);
    endcase
  endfunction

  function automatic frame_verdict_t predict_frame(input logic [BodyBits-1:0] body,
                                                   input logic up, input logic ack);
    logic [DataBits-1:0] xv;
    logic [DataBits-1:0] d;
    logic                ok;
    logic                shortf;
    int                  lim;
    int                  idx;
    frame_verdict_t      res;
    ok = 1'b1;
    shortf = 1'b0;
    res = '0;
    for (int j = 0; j < InfoSkip; j++)
      if (body[BodyBits-1-(2*j+1)]) ok = 1'b0;
    for (int j = 0; j < DataBits; j++)
      xv[DataBits-1-j] = body[BodyBits-1-(2*(j+InfoSkip)+1)];
    d = xv;
    if (ack && (nib(d, 3) == PrefixCallAck || nib(d, 3) == PrefixFifteen)) begin
      d[11:0] = '0;
      shortf = 1'b1;
    end
    for (int j = 0; j < 3; j++)
      if (body[BodyBits-1-2*j] != ~xv[63-j]) ok = 1'b0;
    lim = shortf ? ShortLimit : DataBits;
    for (int j = 3; j < lim; j++)
      if (body[BodyBits-1-2*j] != ~(xv[63-j] ^ xv[66-j])) ok = 1'b0;
    if (!shortf) begin
      for (int j = TailStart; j < OnesStart; j++)
        if (body[BodyBits-1-2*j] != ~xv[66-j]) ok = 1'b0;
      for (int j = OnesStart; j < InfoBits; j++)
        if (body[BodyBits-1-2*j] != 1'b1) ok = 1'b0;
    end
    if (!ok) return res;
    idx = frame_class(d, up);
    if (up && nib(d, 3) == PrefixCallAck && ack) idx = int'(TypeCallAck);
    res.digits = d;
    res.ok = 1'b1;
    res.shortf = shortf;
    res.ftype = (idx < 0) ? 6'd0 : idx[5:0];
    res.known = (idx >= 0);
    return res;
  endfunction

  // inverted systematic code over the digits, info bits 0..5 zero
  function automatic logic [BodyBits-1:0] build_body(input logic [DataBits-1:0] d);
    logic [BodyBits-1:0] body;
    for (int j = 0; j < InfoBits; j++) begin
      body[BodyBits-1-(2*j+1)] = (j < InfoSkip) ? 1'b0 : d[63-(j-InfoSkip)];
      if (j < 3) body[BodyBits-1-2*j] = ~d[63-j];
      else if (j < DataBits) body[BodyBits-1-2*j] = ~(d[63-j] ^ d[66-j]);
      else if (j < OnesStart) body[BodyBits-1-2*j] = ~d[66-j];
      else body[BodyBits-1-2*j] = 1'b1;
    end
    return body;
  endfunction

  function automatic logic [DataBits-1:0] rand_digits();
    logic [DataBits-1:0] d;
    d = rand_word();
    if ($urandom_range(1)) begin
      case ($urandom_range(2))
        0: d = with_dig(d, 6, 4'd0);
        1: d = with_dig(d, 6, 4'd14);
        default: d = with_dig(d, 6, 4'd15);
      endcase
    end
    if ($urandom_range(1)) begin
      case ($urandom_range(5))
        0: d = with_dig(d, 10, 4'd3);
        1: d = with_dig(d, 10, 4'd6);
        2: d = with_dig(d, 10, 4'd7);
        3: d = with_dig(d, 10, 4'd13);
        4: d = with_dig(d, 10, 4'd14);
        default: d = with_dig(d, 10, 4'd15);
      endcase
    end
    if ($urandom_range(1)) begin
      case ($urandom_range(2))
        0: d = with_dig(d, 11, 4'd0);
        1: d = with_dig(d, 11, 4'd2);
        default: d = with_dig(d, 11, 4'd15);
      endcase
    end
    if ($urandom_range(1)) begin
      case ($urandom_range(8))
        0: d = with_tail(d, 12'h000);
        1: d = with_tail(d, 12'h002);
        2: d = with_tail(d, 12'h006);
        3: d = with_tail(d, 12'h007);
        4: d = with_tail(d, 12'h008);
        5: d = with_tail(d, 12'h00e);
        6: d = with_tail(d, 12'h3f0 + 12'($urandom_range(7)));
        7: d = with_tail(d, {4'hf, 8'($urandom)});
        default: d = with_tail(d, {4'h0, 8'($urandom)});
      endcase
    end
    return d;
  endfunction

  // shortened frames get random parity beyond the checked span
  task automatic add_frame(input logic [DataBits-1:0] d, input logic up, input logic ack,
                           input int flip_pos);
    frame_item_t it;
    it.body = build_body(d);
    it.up = up;
    it.ack = ack;
    if (ack && (nib(d, 3) == PrefixCallAck || nib(d, 3) == PrefixFifteen))
      for (int j = ShortLimit; j < InfoBits; j++)
        it.body[BodyBits-1-2*j] = 1'($urandom_range(1));
    if (flip_pos >= 0) it.body[BodyBits-1-flip_pos] = ~it.body[BodyBits-1-flip_pos];
    pending_frames.push_back(it);
  endtask

  task automatic add_raw(input logic [BodyBits-1:0] body, input logic up, input logic ack);
    frame_item_t it;
    it.body = body;
    it.up = up;
    it.ack = ack;
    pending_frames.push_back(it);
  endtask

  task automatic fill_random(input int n);
    int                  r;
    logic [BodyBits-1:0] body;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 82) begin
        add_frame(rand_digits(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  (r < 70) ? -1 : int'($urandom_range(BodyBits-1)));
      end else begin
        body = BodyBits'({$urandom, $urandom, $urandom, $urandom, $urandom});
        if ($urandom_range(1))
          for (int j = 0; j < InfoSkip; j++) body[BodyBits-1-(2*j+1)] = 1'b0;
        add_raw(body, 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end
  endtask

  // sampled on the falling edge so the driver and monitor updates have settled
  task automatic drain();
    while (pending_frames.size() != 0 || s_axis_tvalid || expected_verdicts.size() != 0)
      @(negedge clk_i);
  endtask

  // driver: records the prediction when a frame is taken, then offers the next
  always @(posedge clk_i or negedge rst_ni) begin : drive_frames
    frame_item_t         it;
    logic [BodyBits-1:0] seen;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        seen = {s_axis_tdata[63:0], s_axis_tdata[127:64], s_axis_tdata[139:128]};
        expected_verdicts.push_back(predict_frame(seen, s_axis_tuser[0], s_axis_tuser[1]));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_frames.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          it = pending_frames.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {4'b0, it.body[11:0], it.body[75:12], it.body[139:76]};
          s_axis_tuser <= {it.ack, it.up};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver with a one-shot long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    frame_verdict_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_verdicts.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
      end else begin
        want = expected_verdicts.pop_front();
        if (m_axis_tdata[63:0] !== want.digits) begin
          $error("recovered_digits: expected %h, got %h", want.digits, m_axis_tdata[63:0]);
          errors++;
        end
        if (m_axis_tuser[0] !== want.ok) begin
          $error("frame_ok: expected %b, got %b", want.ok, m_axis_tuser[0]);
          errors++;
        end
        if (m_axis_tuser[1] !== want.shortf) begin
          $error("shortened: expected %b, got %b", want.shortf, m_axis_tuser[1]);
          errors++;
        end
        if (m_axis_tdata[69:64] !== want.ftype) begin
          $error("frame_type: expected %0d, got %0d", want.ftype, m_axis_tdata[69:64]);
          errors++;
        end
        if (m_axis_tuser[2] !== want.known) begin
          $error("type_known: expected %b, got %b", want.known, m_axis_tuser[2]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sender sparse-ish, receiver mostly stalled
    send_idle_pct = 23;
    recv_idle_pct = 72;
    add_raw('0, 1'b0, 1'b0);
    add_raw('1, 1'b1, 1'b1);
    add_frame('0, 1'b0, 1'b0, -1);
    add_frame('1, 1'b1, 1'b0, -1);
    // call acknowledgements, shortened and one not shortened
    add_frame(with_dig(rand_word(), 3, PrefixCallAck), 1'b1, 1'b1, -1);
    add_frame(with_dig(rand_word(), 3, PrefixFifteen), 1'b0, 1'b1, -1);
    add_frame(with_dig(rand_word(), 3, PrefixCallAck), 1'b0, 1'b1, -1);
    add_frame(with_dig(rand_word(), 3, 4'd7), 1'b1, 1'b1, -1);
    // digit signal, consistent and not
    add_frame(with_dig(with_dig(rand_word(), 3, 4'd7), 11, 4'd5), 1'b1, 1'b0, -1);
    add_frame(with_dig(with_dig(rand_word(), 3, 4'd7), 11, 4'd0), 1'b1, 1'b0, -1);
    add_frame(with_dig(with_dig(rand_word(), 3, 4'd7), 11, 4'd15), 1'b1, 1'b0, -1);
    // unassigned prefixes, then types chosen by tail and digit values
    add_frame(with_dig(rand_word(), 3, 4'd3), 1'b1, 1'b0, -1);
    add_frame(with_dig(rand_word(), 3, 4'd2), 1'b0, 1'b0, -1);
    add_frame(with_tail(with_dig(rand_word(), 3, 4'd9), 12'h002), 1'b1, 1'b0, -1);
    add_frame(with_tail(with_dig(rand_word(), 3, 4'd9), 12'h00e), 1'b1, 1'b0, -1);
    add_frame(with_tail(with_dig(rand_word(), 3, 4'd9), 12'h008), 1'b1, 1'b0, -1);
    add_frame(with_tail(with_dig(with_dig(rand_word(), 3, 4'd12), 6, 4'd5), TailIdle),
              1'b0, 1'b0, -1);
    add_frame(with_tail(with_dig(with_dig(rand_word(), 3, 4'd12), 6, 4'd5), 12'h3f4),
              1'b0, 1'b0, -1);
    add_frame(with_dig(with_dig(rand_word(), 3, 4'd5), 6, 4'd15), 1'b0, 1'b0, -1);
    add_frame(with_dig(with_dig(with_dig(rand_word(), 3, 4'd15), 13, 4'd15), 10, 4'd6),
              1'b0, 1'b0, -1);
    add_frame(with_dig(with_dig(rand_word(), 3, 4'd14), 13, 4'd15), 1'b0, 1'b0, -1);
    add_frame(with_dig(with_dig(rand_word(), 3, 4'd3), 6, 4'd15), 1'b0, 1'b0, -1);
    add_frame(with_dig(with_dig(rand_word(), 3, 4'd6), 13, 4'd0), 1'b0, 1'b0, -1);
    // one bad parity bit, one nonzero leading info bit, one bad trailing one
    add_frame(rand_digits(), 1'b0, 1'b0, 100);
    add_frame(rand_digits(), 1'b1, 1'b0, 5);
    add_frame(rand_digits(), 1'b0, 1'b0, 138);
    fill_random(550);
    drain();

    send_idle_pct = 72;
    recv_idle_pct = 23;
    fill_random(550);
    drain();

    // full rate with a long output stall so the pipeline backs up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fill_random(550);
    hold_req = hold_req + 1;
    drain();

    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
